### rtl/core/imugb_pkg.sv
// Shared types and constants for the gyro bias calibration and correction core.
`default_nettype none

package imugb_pkg;

  // Sample element and saturation limits
  typedef logic signed [15:0] s16_t;

  localparam s16_t SAT_MAX = 16'sh7FFF;
  localparam s16_t SAT_MIN = 16'sh8000;

  // Input mode codes as they arrive on the port
  localparam logic [1:0] MODE_CORRECT = 2'd0;
  localparam logic [1:0] MODE_CALIB   = 2'd1;
  localparam logic [1:0] MODE_INVAL   = 2'd2;

  // Reset value of the calibration length register
  localparam logic [15:0] CALIB_COUNT_RST = 16'd64;

  // Depth of the queue between the front and back ends
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Number of gyro axes handled by the back end
  localparam int NAXIS = 3;
  localparam int AXW   = $clog2(NAXIS);

  // Decoded operation carried through the queue
  typedef enum logic [1:0] {
    OP_CORRECT = 2'd0,
    OP_CALIB   = 2'd1,
    OP_INVAL   = 2'd2
  } op_t;

  // One classified beat on its way to the back end
  typedef struct packed {
    op_t                   op;
    logic                  first;   // calibration sample opens a run
    logic                  last;    // calibration sample closes a run
    logic [15:0]           count;   // divisor for the run, never zero
    s16_t [NAXIS-1:0]      accel;
    s16_t [NAXIS-1:0]      gyro;
  } item_t;

  // One result beat
  typedef struct packed {
    s16_t [NAXIS-1:0]      accel;
    s16_t [NAXIS-1:0]      gyro;
    logic                  bias_applied;
    logic                  calib_done;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/imugb_front.sv
// Front end: takes input beats, holds the run length register and tags each calibration sample.
`default_nettype none

module imugb_front
  import imugb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire s16_t        accel_x,
  input  wire s16_t        accel_y,
  input  wire s16_t        accel_z,
  input  wire s16_t        gyro_x,
  input  wire s16_t        gyro_y,
  input  wire s16_t        gyro_z,
  output logic             q_push,
  output item_t            q_item,
  input  wire logic        q_full
);

  logic [15:0] calib_count;
  logic [15:0] calib_seen;
  logic [15:0] calib_seen_next;
  logic [15:0] seen_inc;
  logic [15:0] run_len;
  op_t         op;
  logic        is_first;
  logic        is_last;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // Mode decode; the unused code behaves as a correction
  always_comb begin
    case (mode)
      MODE_CALIB: op = OP_CALIB;
      MODE_INVAL: op = OP_INVAL;
      default:    op = OP_CORRECT;
    endcase
  end

  // Run bookkeeping: a zero length counts as one
  assign run_len  = (calib_count == 16'd0) ? 16'd1 : calib_count;
  assign seen_inc = calib_seen + 16'd1;
  assign is_first = (calib_seen == 16'd0);
  assign is_last  = (seen_inc >= run_len);

  always_comb begin
    calib_seen_next = calib_seen;
    if (q_push && op == OP_CALIB) begin
      calib_seen_next = is_last ? 16'd0 : seen_inc;
    end
  end

  // Item assembly
  always_comb begin
    q_item.op       = op;
    q_item.first    = (op == OP_CALIB) && is_first;
    q_item.last     = (op == OP_CALIB) && is_last;
    q_item.count    = run_len;
    q_item.accel[0] = accel_x;
    q_item.accel[1] = accel_y;
    q_item.accel[2] = accel_z;
    q_item.gyro[0]  = gyro_x;
    q_item.gyro[1]  = gyro_y;
    q_item.gyro[2]  = gyro_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      calib_count <= CALIB_COUNT_RST;
      calib_seen  <= 16'd0;
    end else begin
      if (cfg_we) begin
        calib_count <= cfg_wdata;
      end
      calib_seen <= calib_seen_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/imugb_queue.sv
// Small queue of classified beats between the front and back ends.
`default_nettype none

module imugb_queue
  import imugb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t wr_item,
  output logic       full,
  input  wire logic  pop,
  output item_t      rd_item,
  output logic       empty
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;

  assign full    = (fill == (QAW+1)'(QDEPTH));
  assign empty   = (fill == '0);
  assign rd_item = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  // Pointers and fill level; depth is a power of two so pointers wrap
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + (QAW+1)'(1);
        2'b01:   fill <= fill - (QAW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/imugb_div.sv
// Serial signed-by-unsigned divider, one quotient bit per cycle, result saturated to 16 bits.
`default_nettype none

module imugb_div
  import imugb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] dividend,
  input  wire logic [15:0]        divisor,
  output logic                    done,
  output s16_t                    quot
);

  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [31:0] q;
  logic [15:0] dvsr;
  logic        neg;
  logic [16:0] sh;
  logic [16:0] diff;
  logic [31:0] q_neg;

  // One restoring step
  assign sh   = {rem, q[31]};
  assign diff = sh - {1'b0, dvsr};

  // Sign fix-up and saturation of the magnitude quotient
  assign q_neg = 32'd0 - q;
  always_comb begin
    if (!neg) begin
      quot = (q > 32'd32767) ? SAT_MAX : q[15:0];
    end else begin
      quot = (q > 32'd32768) ? SAT_MIN : q_neg[15:0];
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q    <= dividend[31] ? (32'd0 - dividend) : dividend;
      neg  <= dividend[31];
      rem  <= 16'd0;
      dvsr <= divisor;
    end else if (busy) begin
      if (!diff[16]) begin
        rem <= diff[15:0];
        q   <= {q[30:0], 1'b1};
      end else begin
        rem <= sh[15:0];
        q   <= {q[30:0], 1'b0};
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/imugb_back.sv
// Back end: accumulates calibration sums, runs the bias divisions and corrects samples.
`default_nettype none

module imugb_back
  import imugb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_empty,
  input  wire item_t q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output result_t    res
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DSTART = 4'b0010,
    ST_DWAIT  = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic signed [31:0] gyro_sum  [NAXIS];
  logic signed [31:0] sum_next  [NAXIS];
  s16_t               axis_bias [NAXIS];
  logic               bias_ok;
  logic [AXW-1:0]     axis;
  item_t              cur;
  logic               out_free;
  logic               load;
  result_t            res_next;
  logic               div_start;
  logic               div_done;
  s16_t               div_q;
  s16_t               corr [NAXIS];
  logic signed [16:0] delta [NAXIS];

  assign out_free = !out_valid || !out_stall;

  // Running sums with the head sample added; a run's first sample restarts them
  always_comb begin
    for (int i = 0; i < NAXIS; i++) begin
      sum_next[i] = (q_item.first ? 32'sd0 : gyro_sum[i])
                  + {{16{q_item.gyro[i][15]}}, q_item.gyro[i]};
    end
  end

  // Bias subtraction with 16-bit saturation
  always_comb begin
    for (int i = 0; i < NAXIS; i++) begin
      delta[i] = {q_item.gyro[i][15], q_item.gyro[i]} - {axis_bias[i][15], axis_bias[i]};
      if (delta[i][16] != delta[i][15]) begin
        corr[i] = delta[i][16] ? SAT_MIN : SAT_MAX;
      end else begin
        corr[i] = delta[i][15:0];
      end
    end
  end

  // Sequencer and result selection
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load       = 1'b0;
    div_start  = 1'b0;
    res_next.accel        = q_item.accel;
    res_next.gyro         = q_item.gyro;
    res_next.bias_applied = 1'b0;
    res_next.calib_done   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          case (q_item.op)
            OP_CALIB: begin
              if (q_item.last) begin
                state_next = ST_DSTART;
              end else begin
                load = 1'b1;
              end
            end
            OP_INVAL: begin
              load = 1'b1;
            end
            default: begin
              load = 1'b1;
              if (bias_ok) begin
                for (int i = 0; i < NAXIS; i++) begin
                  res_next.gyro[i] = corr[i];
                end
                res_next.bias_applied = 1'b1;
              end
            end
          endcase
        end
      end
      ST_DSTART: begin
        div_start  = 1'b1;
        state_next = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          state_next = (axis == AXW'(NAXIS - 1)) ? ST_FLUSH : ST_DSTART;
        end
      end
      ST_FLUSH: begin
        res_next.accel      = cur.accel;
        res_next.gyro       = cur.gyro;
        res_next.calib_done = 1'b1;
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Shared divider for the three axes
  imugb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (gyro_sum[axis]),
    .divisor  (cur.count),
    .done     (div_done),
    .quot     (div_q)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      bias_ok   <= 1'b0;
      axis      <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop && q_item.op == OP_INVAL) begin
        bias_ok <= 1'b0;
      end else if (q_pop && q_item.op == OP_CALIB && q_item.first) begin
        bias_ok <= 1'b0;
      end else if (state == ST_DWAIT && div_done && axis == AXW'(NAXIS - 1)) begin
        bias_ok <= 1'b1;
      end
      if (q_pop && q_item.op == OP_CALIB && q_item.last) begin
        axis <= '0;
      end else if (state == ST_DWAIT && div_done) begin
        axis <= axis + AXW'(1);
      end
    end
  end

  // Sums, biases, held item and result register
  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == OP_CALIB) begin
      for (int i = 0; i < NAXIS; i++) begin
        gyro_sum[i] <= sum_next[i];
      end
      cur <= q_item;
    end
    if (rst) begin
      for (int i = 0; i < NAXIS; i++) begin
        axis_bias[i] <= 16'sd0;
      end
    end else if (state == ST_DWAIT && div_done) begin
      axis_bias[axis] <= div_q;
    end
    if (load) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/imu_gyro_bias_calibrate_correct_core.sv
// Top level of the gyro zero-rate bias calibration and correction core.
// Correction, invalidate and ordinary calibration beats pass from input beat to result through
// the queue and the result register; the beat that ends a calibration run waits for the
// shared 32-step serial divider, once for each axis. Throughput: one beat per cycle
// outside that while out_stall is low; the two-entry queue takes up to two more meanwhile.
// Reset (rst, synchronous): run length 64, no run in progress, bias zero and not valid.
`default_nettype none

module imu_gyro_bias_calibrate_correct_core
  import imugb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire s16_t        accel_x,
  input  wire s16_t        accel_y,
  input  wire s16_t        accel_z,
  input  wire s16_t        gyro_x,
  input  wire s16_t        gyro_y,
  input  wire s16_t        gyro_z,
  output logic             out_valid,
  input  wire logic        out_stall,
  output s16_t             out_accel_x,
  output s16_t             out_accel_y,
  output s16_t             out_accel_z,
  output s16_t             out_gyro_x,
  output s16_t             out_gyro_y,
  output s16_t             out_gyro_z,
  output logic             bias_applied,
  output logic             calib_done
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  item_t   wr_item;
  item_t   rd_item;
  result_t res;

  imugb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .gyro_x    (gyro_x),
    .gyro_y    (gyro_y),
    .gyro_z    (gyro_z),
    .q_push    (q_push),
    .q_item    (wr_item),
    .q_full    (q_full)
  );

  imugb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (rd_item),
    .empty   (q_empty)
  );

  imugb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (rd_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  // Result beat onto the ports
  assign out_accel_x  = res.accel[0];
  assign out_accel_y  = res.accel[1];
  assign out_accel_z  = res.accel[2];
  assign out_gyro_x   = res.gyro[0];
  assign out_gyro_y   = res.gyro[1];
  assign out_gyro_z   = res.gyro[2];
  assign bias_applied = res.bias_applied;
  assign calib_done   = res.calib_done;

endmodule

`default_nettype wire
